// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
// Needs a clock and an active-low reset in the including scope's port list.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define PSO_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("pso assertion failed");

// condition must never be seen outside reset
`define PSO_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `PSO_ASSERT(lbl, clk, rstn, !(cond))

`endif

// ===== rtl/core/pso_pkg.sv =====
// Package for the square-wave oscillator: constants, types and helpers.
// No dependencies; used by pso_mul, pso_seq and the top level.
package pso_pkg;

  localparam logic [31:0] SampleStep   = 32'h0001_0000;
  localparam logic [17:0] ModOffset    = 18'd32768;
  localparam logic [15:0] OvershootMax = 16'hFFFF;
  localparam int unsigned ModShift     = 15;
  localparam int unsigned MulAW        = 18;
  localparam int unsigned MulBW        = 33;
  localparam int unsigned MulPW        = MulAW + MulBW;

  typedef enum logic [0:0] {
    CFG_HALF_PERIOD = 1'b0,
    CFG_AMPLITUDE   = 1'b1
  } pso_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_EDGE,
    ST_LEVEL,
    ST_FIN,
    ST_DONE
  } pso_state_e;

  typedef struct packed {
    logic signed [MulAW-1:0] a;
    logic signed [MulBW-1:0] b;
  } pso_mul_req_t;

  function automatic logic [15:0] pso_clamp(input logic [31:0] diff);
    logic [15:0] r;
    if (diff[31]) begin
      r = '0;
    end else if (|diff[30:16]) begin
      r = OvershootMax;
    end else begin
      r = diff[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pso_if.sv =====
// Valid/ready channel interfaces for the oscillator tick and sample streams.
// Depends on nothing beyond the payload widths fixed here.
interface pso_in_if;
  logic               valid;
  logic               ready;
  logic               mod_present;
  logic signed [15:0] mod_sample;

  modport source  (output valid, mod_present, mod_sample, input ready);
  modport sink    (input valid, mod_present, mod_sample, output ready);
  modport monitor (input valid, ready, mod_present, mod_sample);
endinterface

interface pso_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;

  modport source  (output valid, sample_out, input ready);
  modport sink    (input valid, sample_out, output ready);
  modport monitor (input valid, ready, sample_out);
endinterface

// ===== rtl/core/pso_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on pso_pkg for the operand struct and widths.
module pso_mul import pso_pkg::*; (
  input  logic                     clk_i,
  input  pso_mul_req_t             mul_req_i,
  output logic signed [MulPW-1:0]  prod_o
);

  logic signed [MulPW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_req_i.a * mul_req_i.b;
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/core/pso_seq.sv =====
// Sequencer and datapath: phase accumulator, edge compare, output register.
// Depends on pso_pkg and pso_if; drives the shared multiplier.
module pso_seq import pso_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [31:0]             half_period_i,
  input  logic [14:0]             amplitude_i,
  pso_in_if.sink                  req_i,
  pso_out_if.source               res_o,
  output pso_mul_req_t            mul_req_o,
  input  logic signed [MulPW-1:0] prod_i
);

  pso_state_e state_q, state_d;

  logic               mod_p_q;
  logic signed [15:0] mod_s_q;
  logic [31:0]        elapsed_q;
  logic               neg_q;
  logic [15:0]        res_q;
  logic               out_valid_q;
  logic [15:0]        out_data_q;

  logic               accept;
  logic               out_free;
  logic signed [17:0] level;
  logic signed [17:0] s_ext;
  logic signed [17:0] mod_a;
  logic [31:0]        dur;
  logic               below;
  logic signed [17:0] fin_val;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || res_o.ready;

  assign level = neg_q ? (18'sd0 - $signed({3'b000, amplitude_i}))
                       : $signed({3'b000, amplitude_i});
  assign s_ext = {{2{mod_s_q[15]}}, mod_s_q};
  assign mod_a = (neg_q ? (18'sd0 - s_ext) : s_ext) + $signed(ModOffset);
  assign dur   = mod_p_q ? prod_i[ModShift+31:ModShift] : half_period_i;
  assign below = elapsed_q < dur;
  assign fin_val = level - $signed(prod_i[ModShift+17:ModShift]);

  always_comb begin
    state_d   = state_q;
    mul_req_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && (amplitude_i != '0)) state_d = ST_SCALE;
      end
      ST_SCALE: begin
        mul_req_o.a = mod_a;
        mul_req_o.b = $signed({1'b0, half_period_i});
        state_d     = ST_EDGE;
      end
      ST_EDGE: begin
        state_d = below ? ST_DONE : ST_LEVEL;
      end
      ST_LEVEL: begin
        mul_req_o.a = level;
        mul_req_o.b = $signed({17'b0, elapsed_q[15:0]});
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      elapsed_q   <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_SCALE: elapsed_q <= elapsed_q + SampleStep;
        ST_EDGE: begin
          if (!below) elapsed_q <= {16'b0, pso_clamp(elapsed_q - dur)};
        end
        ST_FIN:  neg_q <= ~neg_q;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mod_p_q <= req_i.mod_present;
      mod_s_q <= req_i.mod_sample;
    end
    if (state_q == ST_EDGE && below) res_q <= level[15:0];
    if (state_q == ST_FIN) res_q <= fin_val[15:0];
    if (state_q == ST_DONE && out_free) out_data_q <= res_q;
  end

  assign req_i.ready      = (state_q == ST_IDLE);
  assign res_o.valid      = out_valid_q;
  assign res_o.sample_out = out_data_q;

endmodule

// ===== rtl/core/pwm_square_oscillator.sv =====
// Top level of the smoothed square-wave oscillator: config registers,
// sequencer and shared multiplier. Depends on pso_pkg, pso_if, pso_seq, pso_mul.
//
//   channel  dir  payload                       handshake
//   req_i    in   mod_present, mod_sample[15:0] valid/ready
//   res_o    out  sample_out[15:0]              valid/ready
//   cfg      in   cfg_idx_i, cfg_data_i[31:0]   cfg_we_i, no wait
//
// A request with no polarity edge steps through SCALE, EDGE and DONE before ready again,
// one that crosses an edge adds LEVEL and FIN: the scaling multiply runs on every
// request, an edge adds the interpolation multiply. Zero amplitude: accepted, no sample.
// Reset clears the phase and polarity; the block is ready right after it.
// A stalled output holds the sequencer until the output register is free.
module pwm_square_oscillator import pso_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  pso_in_if.sink      req_i,
  pso_out_if.source   res_o
);

  logic [31:0]             half_period_q;
  logic [14:0]             amplitude_q;
  pso_mul_req_t            mul_req;
  logic signed [MulPW-1:0] prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= '0;
      amplitude_q   <= '0;
    end else if (cfg_we_i) begin
      case (pso_cfg_idx_e'(cfg_idx_i))
        CFG_HALF_PERIOD: half_period_q <= cfg_data_i;
        CFG_AMPLITUDE:   amplitude_q   <= cfg_data_i[14:0];
        default: begin
        end
      endcase
    end
  end

  pso_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .half_period_i (half_period_q),
    .amplitude_i   (amplitude_q),
    .req_i         (req_i),
    .res_o         (res_o),
    .mul_req_o     (mul_req),
    .prod_i        (prod)
  );

  pso_mul u_mul (
    .clk_i     (clk_i),
    .mul_req_i (mul_req),
    .prod_o    (prod)
  );

endmodule

// ===== rtl/core/pso_checker.sv =====
// Port-level checker for the oscillator, bound to the top level.
// Depends on the top level's handshake ports and assert_macros.svh.
`include "assert_macros.svh"

module pso_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [15:0] sample_out_i
);

  `PSO_ASSERT(a_out_hold, clk_i, rst_ni, (res_valid_i && !res_ready_i) |=> res_valid_i)
  `PSO_ASSERT(a_out_stable, clk_i, rst_ni, (res_valid_i && !res_ready_i) |=> $stable(sample_out_i))
  `PSO_ASSERT_NEVER(a_no_min, clk_i, rst_ni, res_valid_i && (sample_out_i == 16'h8000))
  `PSO_ASSERT(a_min_latency, clk_i, rst_ni, $rose(res_valid_i) |-> !$past(req_valid_i && req_ready_i))

endmodule

bind pwm_square_oscillator pso_checker u_pso_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .sample_out_i (res_o.sample_out)
);
